/* rtl/merge_running_variance_defines.svh */
// ----------------------------------------------------------------------------
// Merge running variance: assertion macros
// Short helpers for the concurrent checks of the merge block.
// ----------------------------------------------------------------------------
`ifndef MERGE_RUNNING_VARIANCE_DEFINES_SVH
`define MERGE_RUNNING_VARIANCE_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define MRV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("merge_running_variance: check failed");

// Next-cycle implication, sampled on clk and masked during reset.
`define MRV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("merge_running_variance: check failed");

`endif

/* rtl/mrv_pkg.sv */
// ----------------------------------------------------------------------------
// Merge running variance package
// Widths, sequencer states and the divider command struct shared by the block.
// ----------------------------------------------------------------------------
package mrv_pkg;

    localparam int DVD_W   = 128;  // divider dividend and quotient width
    localparam int DSR_W   = 33;   // divider divisor width (sum of two counts)
    localparam int DCNT_W  = 7;    // divider step counter width
    localparam int RAD_W   = 88;   // square root radicand width (Q40.24 << 24)
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SCNT_W  = 6;    // square root step counter width
    localparam int MCNT_W  = 4;    // multiply step counter width

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ABS,
        S_MUL,
        S_DIVQ_L,
        S_DIVQ_W,
        S_DIVT_L,
        S_DIVT_W,
        S_UPD,
        S_SQ1_L,
        S_SQ1_W,
        S_SQ2_L,
        S_SQ2_W,
        S_FIN
    } mrv_state_t;

    typedef struct packed {
        logic              start;
        logic [DCNT_W-1:0] nbits;
    } mrv_div_cmd_t;

endpackage

/* rtl/mrv_div.sv */
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle from a left-aligned dividend.
// ----------------------------------------------------------------------------
module mrv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrv_pkg::mrv_div_cmd_t         cmd,
    input  logic [mrv_pkg::DVD_W-1:0]     dividend,
    input  logic [mrv_pkg::DSR_W-1:0]     divisor,
    output logic                          busy,
    output logic [mrv_pkg::DVD_W-1:0]     quotient
);
    import mrv_pkg::*;

    logic              busy_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cmd.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dvd_reg <= dividend;
            quo_reg <= '0;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/mrv_sqrt.sv */
// ----------------------------------------------------------------------------
// Serial integer square root
// Digit-by-digit root, one result bit per cycle, floor of the true root.
// ----------------------------------------------------------------------------
module mrv_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mrv_pkg::RAD_W-1:0]     radicand,
    output logic                          busy,
    output logic [mrv_pkg::ROOT_W-1:0]    root
);
    import mrv_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic              busy_reg;
    logic [SCNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W:0]    shifted;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;

    always_comb
    begin
        shifted = {rem_reg[REM_W-2:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial   = {1'b0, root_reg, 2'b01};
        diff    = shifted - trial;
        ge      = (shifted >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= SCNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SCNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* rtl/merge_running_variance.sv */
// ----------------------------------------------------------------------------
// Merge running variance
// Merges partial statistics into a stored accumulator by the pairwise update.
// ----------------------------------------------------------------------------
// Usage: each input beat carries a partial statistic (mean Q8.24, M2 Q40.24,
// count) and a restart flag that empties the accumulator first. The block
// merges it and returns one output beat with the merged mean, sqrt(M2)/n,
// sqrt(M2/n), the count and two flags. Both channels are valid/ready.
// in_ready is high only while the sequencer is idle; one beat is worked on
// at a time. After a beat is accepted, the shared 32x32 multiplier forms
// its products, then the serial divider runs for 64 and 104 bits, then the
// divider and the square root unit run side by side twice, for 88 and 44
// bits and then for 44 and 44 bits. The divider makes one quotient bit per
// cycle. The next beat can be taken in the cycle in which out_valid rises.
// An empty merge skips the multiplier, divider and square root steps and
// frees the input in the same cycle as its result shows.
// The result sits in an output register, so the next beat is accepted while
// it waits; a stalled receiver only holds the sequencer at its final step.
// Reset clears the accumulator to zero and drops out_valid.
// ----------------------------------------------------------------------------
module merge_running_variance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  logic [31:0] part_mean,
    input  logic [63:0] part_m2,
    input  logic [31:0] part_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] merged_mean,
    output logic [31:0] merged_err,
    output logic [31:0] merged_rms,
    output logic [31:0] merged_count,
    output logic        empty_fault,
    output logic        saturated
);
    import mrv_pkg::*;

`include "merge_running_variance_defines.svh"

    mrv_state_t state_reg, state_next;
    logic [MCNT_W-1:0] k_reg;

    // Accumulator.
    logic [31:0] acc_mean_reg;
    logic [63:0] acc_m2_reg;
    logic [31:0] acc_count_reg;

    // Working registers for one merge.
    logic [31:0]  pm_reg, pc_reg, m1_reg, n1_reg;
    logic [63:0]  pm2_reg, m2a_reg, m2s_reg, m2_reg;
    logic [32:0]  n_reg, delta_reg;
    logic [31:0]  ad_reg, mean_reg, cnt_reg;
    logic         neg_reg, sat_reg, empty_reg;
    logic [63:0]  prod_reg, qprod_reg, x_reg, y_reg;
    logic [127:0] wacc_reg;

    // Output register.
    logic        out_valid_reg;
    logic [31:0] o_mean_reg, o_err_reg, o_rms_reg, o_count_reg;
    logic        o_empty_reg, o_sat_reg;

    // Shared units and their controls.
    mrv_div_cmd_t      div_cmd;
    logic [DVD_W-1:0]  div_dividend;
    logic [DSR_W-1:0]  div_divisor;
    logic              div_busy;
    logic [DVD_W-1:0]  div_quo;
    logic              sq_start;
    logic [RAD_W-1:0]  sq_rad;
    logic              sq_busy;
    logic [ROOT_W-1:0] sq_root;
    logic [31:0]       mul_a, mul_b;

    logic        slot_free;
    logic        units_idle;
    logic [64:0] m2_sum;
    logic [64:0] m2_fin;
    logic        term_big;

    assign slot_free  = !out_valid_reg || out_ready;
    assign units_idle = !div_busy && !sq_busy;
    assign m2_sum     = {1'b0, m2a_reg} + {1'b0, pm2_reg};
    assign m2_fin     = {1'b0, m2s_reg} + {1'b0, div_quo[63:0]};
    assign term_big   = |div_quo[DVD_W-1:64];

    mrv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    mrv_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_PREP;
            S_PREP:   state_next = S_ABS;
            S_ABS:    state_next = (n_reg == '0) ? S_FIN : S_MUL;
            S_MUL:    if (k_reg == MCNT_W'(8)) state_next = S_DIVQ_L;
            S_DIVQ_L: state_next = S_DIVQ_W;
            S_DIVQ_W: if (!div_busy) state_next = S_DIVT_L;
            S_DIVT_L: state_next = S_DIVT_W;
            S_DIVT_W: if (!div_busy) state_next = S_UPD;
            S_UPD:    state_next = S_SQ1_L;
            S_SQ1_L:  state_next = S_SQ1_W;
            S_SQ1_W:  if (units_idle) state_next = S_SQ2_L;
            S_SQ2_L:  state_next = S_SQ2_W;
            S_SQ2_W:  if (units_idle) state_next = S_FIN;
            S_FIN:    if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: unit commands and multiplier operands.
    always_comb
    begin
        in_ready      = 1'b0;
        div_cmd.start = 1'b0;
        div_cmd.nbits = '0;
        div_dividend  = '0;
        div_divisor   = n_reg;
        sq_start      = 1'b0;
        sq_rad        = '0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_MUL:
            begin
                case (k_reg)
                    MCNT_W'(0):
                    begin
                        mul_a = pc_reg;
                        mul_b = ad_reg;
                    end
                    MCNT_W'(1):
                    begin
                        mul_a = n1_reg;
                        mul_b = pc_reg;
                    end
                    MCNT_W'(2):
                    begin
                        mul_a = ad_reg;
                        mul_b = ad_reg;
                    end
                    MCNT_W'(4):
                    begin
                        mul_a = x_reg[31:0];
                        mul_b = y_reg[31:0];
                    end
                    MCNT_W'(5):
                    begin
                        mul_a = x_reg[31:0];
                        mul_b = y_reg[63:32];
                    end
                    MCNT_W'(6):
                    begin
                        mul_a = x_reg[63:32];
                        mul_b = y_reg[31:0];
                    end
                    MCNT_W'(7):
                    begin
                        mul_a = x_reg[63:32];
                        mul_b = y_reg[63:32];
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_DIVQ_L:
            begin
                div_cmd.start = 1'b1;
                div_cmd.nbits = DCNT_W'(64);
                div_dividend  = {qprod_reg, 64'b0};
            end
            S_DIVT_L:
            begin
                div_cmd.start = 1'b1;
                div_cmd.nbits = DCNT_W'(104);
                div_dividend  = {wacc_reg[127:24], 24'b0};
            end
            S_SQ1_L:
            begin
                // sqrt(M2 << 24) and (M2 << 24) / count run together.
                div_cmd.start = 1'b1;
                div_cmd.nbits = DCNT_W'(RAD_W);
                div_dividend  = {m2_reg, 24'b0, 40'b0};
                div_divisor   = {1'b0, cnt_reg};
                sq_start      = 1'b1;
                sq_rad        = {m2_reg, 24'b0};
            end
            S_SQ2_L:
            begin
                // Root from the first pass over count; root of the quotient.
                div_cmd.start = 1'b1;
                div_cmd.nbits = DCNT_W'(ROOT_W);
                div_dividend  = {sq_root, {(DVD_W-ROOT_W){1'b0}}};
                div_divisor   = {1'b0, cnt_reg};
                sq_start      = 1'b1;
                sq_rad        = div_quo[RAD_W-1:0];
            end
            default: ;
        endcase
    end

    // Control state, accumulator and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            acc_mean_reg  <= '0;
            acc_m2_reg    <= '0;
            acc_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= (state_reg == S_MUL) ? k_reg + 1'b1 : '0;
            if (state_reg == S_UPD)
            begin
                acc_mean_reg  <= mean_reg;
                acc_m2_reg    <= m2_reg;
                acc_count_reg <= cnt_reg;
            end
            if (state_reg == S_FIN && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pm_reg  <= part_mean;
                    pm2_reg <= part_m2;
                    pc_reg  <= part_count;
                    m1_reg  <= restart ? 32'd0 : acc_mean_reg;
                    n1_reg  <= restart ? 32'd0 : acc_count_reg;
                    m2a_reg <= restart ? 64'd0 : acc_m2_reg;
                end
            end
            S_PREP:
            begin
                n_reg     <= {1'b0, n1_reg} + {1'b0, pc_reg};
                delta_reg <= {pm_reg[31], pm_reg} - {m1_reg[31], m1_reg};
                m2s_reg   <= m2_sum[64] ? '1 : m2_sum[63:0];
                sat_reg   <= m2_sum[64];
            end
            S_ABS:
            begin
                neg_reg   <= delta_reg[32];
                ad_reg    <= delta_reg[32] ? 32'(-delta_reg) : delta_reg[31:0];
                empty_reg <= (n_reg == '0);
            end
            S_MUL:
            begin
                case (k_reg)
                    MCNT_W'(1): qprod_reg <= prod_reg;
                    MCNT_W'(2): x_reg     <= prod_reg;
                    MCNT_W'(3): y_reg     <= prod_reg;
                    MCNT_W'(4): wacc_reg  <= '0;
                    MCNT_W'(5): wacc_reg  <= wacc_reg + {64'b0, prod_reg};
                    MCNT_W'(6): wacc_reg  <= wacc_reg + {32'b0, prod_reg, 32'b0};
                    MCNT_W'(7): wacc_reg  <= wacc_reg + {32'b0, prod_reg, 32'b0};
                    MCNT_W'(8): wacc_reg  <= wacc_reg + {prod_reg, 64'b0};
                    default: ;
                endcase
            end
            S_DIVQ_W:
            begin
                if (!div_busy)
                    mean_reg <= neg_reg ? m1_reg - div_quo[31:0]
                                        : m1_reg + div_quo[31:0];
            end
            S_DIVT_W:
            begin
                if (!div_busy)
                begin
                    m2_reg  <= (term_big || m2_fin[64]) ? '1 : m2_fin[63:0];
                    cnt_reg <= n_reg[32] ? '1 : n_reg[31:0];
                    sat_reg <= sat_reg || term_big || m2_fin[64] || n_reg[32];
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    o_empty_reg <= empty_reg;
                    if (empty_reg)
                    begin
                        o_mean_reg  <= '0;
                        o_err_reg   <= '0;
                        o_rms_reg   <= '0;
                        o_count_reg <= '0;
                        o_sat_reg   <= 1'b0;
                    end
                    else
                    begin
                        o_mean_reg  <= mean_reg;
                        o_err_reg   <= (|div_quo[ROOT_W-1:32]) ? '1 : div_quo[31:0];
                        o_rms_reg   <= (|sq_root[ROOT_W-1:32]) ? '1 : sq_root[31:0];
                        o_count_reg <= cnt_reg;
                        o_sat_reg   <= sat_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign merged_mean  = o_mean_reg;
    assign merged_err   = o_err_reg;
    assign merged_rms   = o_rms_reg;
    assign merged_count = o_count_reg;
    assign empty_fault  = o_empty_reg;
    assign saturated    = o_sat_reg;

    // An empty merge reports nothing but the fault flag.
    `MRV_ASSERT_NOW(a_empty_clean, out_valid_reg && o_empty_reg, o_count_reg == '0 && !o_sat_reg)
    // A real merge never reports a zero count.
    `MRV_ASSERT_NOW(a_count_nonzero, out_valid_reg && !o_empty_reg, o_count_reg != '0)
    // Launching the quotient or term divide always leaves the divider running in the wait step.
    `MRV_ASSERT_NEXT(a_div_launch, state_reg == S_DIVQ_L || state_reg == S_DIVT_L, div_busy)

endmodule
